FILE: rtl/assert_macros.svh
// assertion macros shared by the accelerometer datapath
// expects signals named clk and rst in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define ACG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define ACG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/acg_pkg.sv
// shared widths, register indexes and types for the accelerometer datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package acg_pkg;

  localparam int CNT_W      = 16;
  localparam int CPG_W      = 15;
  localparam int OUT_W      = 18;
  localparam int SUM_W      = 2 * OUT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ZERO = 3'd0,
    REG_Y_ZERO = 3'd1,
    REG_Z_ZERO = 3'd2,
    REG_X_CPG  = 3'd3,
    REG_Y_CPG  = 3'd4,
    REG_Z_CPG  = 3'd5
  } cfg_reg_t;

  // reset values
  localparam logic [CNT_W-1:0] X_ZERO_RST = 16'd32813;
  localparam logic [CNT_W-1:0] Y_ZERO_RST = 16'd32278;
  localparam logic [CNT_W-1:0] Z_ZERO_RST = 16'd34374;
  localparam logic [CPG_W-1:0] X_CPG_RST  = 15'd6626;
  localparam logic [CPG_W-1:0] Y_CPG_RST  = 15'd6537;
  localparam logic [CPG_W-1:0] Z_CPG_RST  = 15'd6809;

  typedef logic signed [OUT_W-1:0] accel_t;

  typedef struct packed {
    accel_t x;
    accel_t y;
    accel_t z;
  } accel3_t;

endpackage

`default_nettype wire

FILE: rtl/acg_in_if.sv
// sample channel: three raw converter counts per beat
// depends on acg_pkg
`timescale 1ns / 1ps
`default_nettype none

interface acg_in_if;
  logic                      valid;
  logic                      ready;
  logic [acg_pkg::CNT_W-1:0] x_count;
  logic [acg_pkg::CNT_W-1:0] y_count;
  logic [acg_pkg::CNT_W-1:0] z_count;

  modport source(output valid, x_count, y_count, z_count, input ready);
  modport sink(input valid, x_count, y_count, z_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/acg_out_if.sv
// result channel: three axis accelerations and magnitude per beat
// depends on acg_pkg
`timescale 1ns / 1ps
`default_nettype none

interface acg_out_if;
  logic                    valid;
  logic                    ready;
  logic signed [acg_pkg::OUT_W-1:0] x_accel;
  logic signed [acg_pkg::OUT_W-1:0] y_accel;
  logic signed [acg_pkg::OUT_W-1:0] z_accel;
  logic signed [acg_pkg::OUT_W-1:0] magnitude_less_one;

  modport source(output valid, x_accel, y_accel, z_accel, magnitude_less_one,
                 input ready);
  modport sink(input valid, x_accel, y_accel, z_accel, magnitude_less_one,
               output ready);
endinterface

`default_nettype wire

FILE: rtl/acg_lane.sv
// one axis lane: offset, pipelined restoring divide, saturate, square
// depends on acg_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module acg_lane #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        v_in,
  input  wire logic [acg_pkg::CNT_W-1:0]   count,
  input  wire logic [acg_pkg::CNT_W-1:0]   zero,
  input  wire logic [acg_pkg::CPG_W-1:0]   cpg,
  output logic                             v_out,
  output acg_pkg::accel_t                  accel,
  output logic [acg_pkg::SUM_W-1:0]        sq
);

  `include "assert_macros.svh"

  localparam int QB = acg_pkg::OUT_W;
  localparam int DW = acg_pkg::CPG_W + 1;
  localparam int NW = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int EW = (NW > DW + QB + 1) ? NW : DW + QB + 1;
  localparam logic [QB-1:0] LIM = QB'(1) << (QB - 1);

  // front end: offset magnitude, scaled numerator, doubled divisor
  logic [SAMPLE_BITS-1:0]  c_s, z_s, mag;
  logic [acg_pkg::CPG_W-1:0] d;
  logic                    neg_n;
  logic [EW-1:0]           num;
  logic [DW-1:0]           den_n;
  logic                    ovf_n;

  always_comb begin
    c_s   = count[SAMPLE_BITS-1:0];
    z_s   = zero[SAMPLE_BITS-1:0];
    d     = (cpg == '0) ? acg_pkg::CPG_W'(1) : cpg;
    neg_n = c_s > z_s;
    mag   = neg_n ? (c_s - z_s) : (z_s - c_s);
    num   = (EW'(mag) << (FRAC_BITS + 1)) + EW'(d);
    den_n = {d, 1'b0};
    ovf_n = num >= (EW'(den_n) << QB);
  end

  // divide pipeline, stage 0 holds the front end result
  logic          vld [0:QB];
  logic [EW-1:0] rem [0:QB];
  logic [QB-1:0] q   [0:QB];
  logic [DW-1:0] den [0:QB];
  logic          ovf [0:QB];
  logic          neg [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      q[0]   <= '0;
      den[0] <= den_n;
      ovf[0] <= ovf_n;
      neg[0] <= neg_n;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    localparam int K = QB - 1 - i;
    logic [EW-1:0] trial;
    logic          ge;
    logic [QB-1:0] qn;

    // one quotient bit per stage
    always_comb begin
      trial = EW'(den[i]) << K;
      ge    = rem[i] >= trial;
      qn    = q[i];
      qn[K] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? (rem[i] - trial) : rem[i];
        q[i+1]   <= qn;
        den[i+1] <= den[i];
        ovf[i+1] <= ovf[i];
        neg[i+1] <= neg[i];
      end
    end
  end

  // saturate to the signed result range and apply sign
  logic [QB-1:0] a_n;
  logic [QB-1:0] g_n;

  always_comb begin
    if (neg[QB]) begin
      a_n = (ovf[QB] || q[QB] > LIM) ? LIM : q[QB];
    end else begin
      a_n = (ovf[QB] || q[QB] >= LIM) ? (LIM - QB'(1)) : q[QB];
    end
    g_n = neg[QB] ? (QB'(0) - a_n) : a_n;
  end

  logic          vld_s, vld_q;
  logic [QB-1:0] a_r, g_r, g_q;
  logic [acg_pkg::SUM_W-1:0] sq_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s <= 1'b0;
      vld_q <= 1'b0;
    end else if (en) begin
      vld_s <= vld[QB];
      vld_q <= vld_s;
    end
  end

  // square of the saturated magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_n;
      g_r  <= g_n;
      sq_q <= acg_pkg::SUM_W'(a_r) * acg_pkg::SUM_W'(a_r);
      g_q  <= g_r;
    end
  end

  assign v_out = vld_q;
  assign accel = $signed(g_q);
  assign sq    = sq_q;

  `ACG_ASSERT(a_sq_bound, vld_q |-> (sq_q <= (acg_pkg::SUM_W'(1) << (2 * (QB - 1)))), "lane square above full scale")

endmodule

`default_nettype wire

FILE: rtl/acg_mag.sv
// merge stage: sum of lane squares, pipelined square root, round, minus one g
// depends on acg_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module acg_mag #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       v_in,
  input  wire acg_pkg::accel3_t           acc_in,
  input  wire logic [acg_pkg::SUM_W-1:0]  sqx,
  input  wire logic [acg_pkg::SUM_W-1:0]  sqy,
  input  wire logic [acg_pkg::SUM_W-1:0]  sqz,
  output logic                            v_out,
  output acg_pkg::accel3_t                acc_out,
  output acg_pkg::accel_t                 mag_out
);

  `include "assert_macros.svh"

  localparam int OW = acg_pkg::OUT_W;
  localparam int SW = acg_pkg::SUM_W;
  localparam int SQ = SW / 2;
  localparam int RW = SW + 1;
  localparam logic signed [OW+1:0] ONE_G = (OW + 2)'(1) << FRAC_BITS;
  localparam logic signed [OW+1:0] MAXW  = ((OW + 2)'(1) << (OW - 1)) - (OW + 2)'(1);

  logic             vld [0:SQ];
  logic [RW-1:0]    s   [0:SQ];
  logic [RW-1:0]    r   [0:SQ];
  acg_pkg::accel3_t acc [0:SQ];

  // sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s[0]   <= RW'(sqx) + RW'(sqy) + RW'(sqz);
      r[0]   <= '0;
      acc[0] <= acc_in;
    end
  end

  // one root bit per stage
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (SW - 2 - 2 * j);
    logic [RW-1:0] t;
    logic          ge;

    always_comb begin
      t  = r[j] + BIT;
      ge = s[j] >= t;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s[j+1]   <= ge ? (s[j] - t) : s[j];
        r[j+1]   <= ge ? ((r[j] >> 1) + BIT) : (r[j] >> 1);
        acc[j+1] <= acc[j];
      end
    end
  end

  // round to nearest, subtract one g, saturate
  logic [OW:0]          rr;
  logic signed [OW+1:0] m;
  acg_pkg::accel_t      mag_n;

  always_comb begin
    rr = {1'b0, r[SQ][OW-1:0]} + (OW + 1)'(s[SQ] > r[SQ]);
    m  = $signed({1'b0, rr}) - ONE_G;
    if (m > MAXW) begin
      mag_n = MAXW[OW-1:0];
    end else begin
      mag_n = m[OW-1:0];
    end
  end

  logic             vld_o;
  acg_pkg::accel3_t acc_o;
  acg_pkg::accel_t  mag_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_o <= acc[SQ];
      mag_o <= mag_n;
    end
  end

  assign v_out   = vld_o;
  assign acc_out = acc_o;
  assign mag_out = mag_o;

  `ACG_ASSERT(a_root_rem, vld[SQ] |-> (s[SQ] <= (r[SQ] << 1)), "square root remainder out of range")

endmodule

`default_nettype wire

FILE: rtl/accel_counts_to_g_and_magnitude.sv
// top level: config registers, three axis lanes, magnitude merge, output skid
// depends on acg_pkg, acg_in_if, acg_out_if, acg_lane, acg_mag, assert_macros.svh
//
// channel  | dir | beat contents
// sample   | in  | x_count, y_count, z_count (16 bit raw counts)
// result   | out | x_accel, y_accel, z_accel, magnitude_less_one (Q6.12)
// cfg      | in  | cfg_wr_en, cfg_index, cfg_data (write only)
//
// one sample accepted per cycle while the skid register is empty; a sample
// passes the lane front end register, the bit-per-stage divide, the saturate
// and square registers, then the sum register, OUT_W root stages and the output
// register; a result not taken parks in a skid register; ready drops only while it is full
// synchronous reset restores the register defaults and empties the pipeline
`timescale 1ns / 1ps
`default_nettype none

module accel_counts_to_g_and_magnitude #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  acg_in_if.sink                                 sample,
  acg_out_if.source                              result,
  input  wire logic                              cfg_wr_en,
  input  wire logic [acg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [acg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  `include "assert_macros.svh"

  localparam acg_pkg::accel_t MAG_FLOOR = -(acg_pkg::OUT_W'(1) << FRAC_BITS);

  // configuration registers
  logic [acg_pkg::CNT_W-1:0] zero_cnt [0:2];
  logic [acg_pkg::CPG_W-1:0] cpg      [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_cnt[0] <= acg_pkg::X_ZERO_RST;
      zero_cnt[1] <= acg_pkg::Y_ZERO_RST;
      zero_cnt[2] <= acg_pkg::Z_ZERO_RST;
      cpg[0]      <= acg_pkg::X_CPG_RST;
      cpg[1]      <= acg_pkg::Y_CPG_RST;
      cpg[2]      <= acg_pkg::Z_CPG_RST;
    end else if (cfg_wr_en) begin
      case (acg_pkg::cfg_reg_t'(cfg_index))
        acg_pkg::REG_X_ZERO: zero_cnt[0] <= cfg_data;
        acg_pkg::REG_Y_ZERO: zero_cnt[1] <= cfg_data;
        acg_pkg::REG_Z_ZERO: zero_cnt[2] <= cfg_data;
        acg_pkg::REG_X_CPG:  cpg[0] <= cfg_data[acg_pkg::CPG_W-1:0];
        acg_pkg::REG_Y_CPG:  cpg[1] <= cfg_data[acg_pkg::CPG_W-1:0];
        acg_pkg::REG_Z_CPG:  cpg[2] <= cfg_data[acg_pkg::CPG_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and input handshake
  logic skid_full;
  logic en;
  logic take;

  assign en           = !skid_full;
  assign sample.ready = !skid_full;
  assign take         = sample.valid && sample.ready;

  // axis lanes
  logic [acg_pkg::CNT_W-1:0] counts [0:2];
  logic                      lane_v [0:2];
  acg_pkg::accel_t           lane_g [0:2];
  logic [acg_pkg::SUM_W-1:0] lane_sq [0:2];

  assign counts[0] = sample.x_count;
  assign counts[1] = sample.y_count;
  assign counts[2] = sample.z_count;

  for (genvar a = 0; a < 3; a++) begin : g_lane
    acg_lane #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .v_in (take),
      .count(counts[a]),
      .zero (zero_cnt[a]),
      .cpg  (cpg[a]),
      .v_out(lane_v[a]),
      .accel(lane_g[a]),
      .sq   (lane_sq[a])
    );
  end

  // merge lanes into magnitude
  acg_pkg::accel3_t lane_acc;
  logic             m_valid;
  acg_pkg::accel3_t m_acc;
  acg_pkg::accel_t  m_mag;

  assign lane_acc = '{x: lane_g[0], y: lane_g[1], z: lane_g[2]};

  acg_mag #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mag (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .v_in   (lane_v[0]),
    .acc_in (lane_acc),
    .sqx    (lane_sq[0]),
    .sqy    (lane_sq[1]),
    .sqz    (lane_sq[2]),
    .v_out  (m_valid),
    .acc_out(m_acc),
    .mag_out(m_mag)
  );

  // output skid register
  acg_pkg::accel3_t skid_acc;
  acg_pkg::accel_t  skid_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (result.ready) begin
        skid_full <= 1'b0;
      end
    end else if (m_valid && !result.ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_acc <= m_acc;
      skid_mag <= m_mag;
    end
  end

  assign result.valid              = skid_full || m_valid;
  assign result.x_accel            = skid_full ? skid_acc.x : m_acc.x;
  assign result.y_accel            = skid_full ? skid_acc.y : m_acc.y;
  assign result.z_accel            = skid_full ? skid_acc.z : m_acc.z;
  assign result.magnitude_less_one = skid_full ? skid_mag : m_mag;

  `ACG_ASSERT(a_stall_has_beat, !sample.ready |-> result.valid, "input stalled with no result pending")
  `ACG_ASSERT(a_mag_floor, result.valid |-> (result.magnitude_less_one >= MAG_FLOOR), "magnitude below minus one g")
  `ACG_ASSERT(a_lanes_aligned, (lane_v[0] == lane_v[1]) && (lane_v[0] == lane_v[2]), "axis lanes out of step")
  `ACG_ASSERT_ALWAYS(a_reset_empty, rst |=> !result.valid, "result valid right after reset")

endmodule

`default_nettype wire
